// File: hw/rtl/rsh_pkg.sv
// shared types and constants for the rgb and sum histogram unit
`timescale 1ns / 1ps

package rsh_pkg;

    localparam int ROW_W      = 8;
    localparam int ROWS       = 256;
    localparam int SAMPLE_W   = 8;
    localparam int SUM_W      = 10;
    localparam int SUM_BANKS  = 3;
    localparam int BANKS      = 6;
    localparam int OUT_W      = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = BANKS * OUT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int BANK_RED   = 0;
    localparam int BANK_GREEN = 1;
    localparam int BANK_BLUE  = 2;
    localparam int BANK_SUM0  = 3;

    typedef struct packed {
        logic                   is_read;
        logic                   clear;
        logic [SUM_BANKS-1:0]   sum_en;
        logic [ROW_W-1:0]       addr_red;
        logic [ROW_W-1:0]       addr_green;
        logic [ROW_W-1:0]       addr_blue;
        logic [ROW_W-1:0]       addr_sum;
    } item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// File: hw/rtl/rgb_and_sum_histogram_unit.sv
// top level of the rgb and sum histogram unit
//
//  channel  dir  signals                      contents
//  s        in   s_tvalid s_tready s_tdata    pixel or row read request
//                s_tuser                      operation
//  m        out  m_tvalid m_tready m_tdata    six counts of one row
//
// a count transaction is a read-modify-write over the bin memories; a read transaction
// also waits on m_tready while the result register is full
// after reset a clearing pass zeroes all 256 rows of every bin memory; s_tready is low
// a four-entry queue lets the input side run ahead of the bin sequencer
// a finished row waits in the result register while the next transactions go on
`timescale 1ns / 1ps

module rgb_and_sum_histogram_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // red, green, blue, row_index, clear_after_read, zero pad
    input  logic [rsh_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red_count, green_count, blue_count, sum_count_low, sum_count_mid,
    // sum_count_high
    output logic [rsh_pkg::OUT_DATA_W-1:0] m_tdata
);

    rsh_pkg::back_status_t status;
    rsh_pkg::item_t        push_item;
    rsh_pkg::item_t        pop_item;
    logic                  push_valid;
    logic                  push_ready;
    logic                  pop_valid;
    logic                  pop_ready;

    rsh_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rsh_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hw/rtl/rsh_front.sv
// front end: accepts transactions and turns them into bank addresses and enables
`timescale 1ns / 1ps

module rsh_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsh_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  rsh_pkg::back_status_t         status,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rsh_pkg::item_t                push_item
);

    logic [rsh_pkg::SAMPLE_W-1:0] red;
    logic [rsh_pkg::SAMPLE_W-1:0] green;
    logic [rsh_pkg::SAMPLE_W-1:0] blue;
    logic [rsh_pkg::ROW_W-1:0]    row_index;
    logic                         clear_after_read;
    logic [rsh_pkg::SUM_W-1:0]    sum;

    assign red              = s_tdata[7:0];
    assign green            = s_tdata[15:8];
    assign blue             = s_tdata[23:16];
    assign row_index        = s_tdata[31:24];
    assign clear_after_read = s_tdata[32];

    assign sum = {2'b00, red} + {2'b00, green} + {2'b00, blue};

    always_comb
    begin
        push_item         = '0;
        push_item.is_read = (s_tuser == rsh_pkg::OP_READ);
        if (s_tuser == rsh_pkg::OP_READ)
        begin
            push_item.clear      = clear_after_read;
            push_item.sum_en     = '1;
            push_item.addr_red   = row_index;
            push_item.addr_green = row_index;
            push_item.addr_blue  = row_index;
            push_item.addr_sum   = row_index;
        end
        else
        begin
            push_item.clear      = 1'b0;
            push_item.addr_red   = red;
            push_item.addr_green = green;
            push_item.addr_blue  = blue;
            push_item.addr_sum   = sum[rsh_pkg::ROW_W-1:0];
            unique case (sum[rsh_pkg::SUM_W-1:rsh_pkg::ROW_W])
                2'd0:    push_item.sum_en = 3'b001;
                2'd1:    push_item.sum_en = 3'b010;
                2'd2:    push_item.sum_en = 3'b100;
                default: push_item.sum_en = 3'b000;
            endcase
        end
    end

    assign push_valid = s_tvalid && !status.clearing;
    assign s_tready   = push_ready && !status.clearing;

endmodule

// File: hw/rtl/rsh_queue.sv
// small queue of classified items between front and back
`timescale 1ns / 1ps

module rsh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rsh_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rsh_pkg::item_t pop_item
);

    rsh_pkg::item_t              entry_reg [rsh_pkg::QUEUE_DEPTH];
    logic [rsh_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [rsh_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [rsh_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [rsh_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [rsh_pkg::QPTR_W:0]    count_reg;
    logic [rsh_pkg::QPTR_W:0]    count_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (count_reg != (rsh_pkg::QPTR_W+1)'(rsh_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/rsh_back.sv
// back end: bin memories, read-modify-write sequencer and result register
`timescale 1ns / 1ps

module rsh_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  rsh_pkg::item_t                 pop_item,
    output rsh_pkg::back_status_t          status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rsh_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [rsh_pkg::ROW_W-1:0]       clr_cnt_reg;
    logic [rsh_pkg::ROW_W-1:0]       clr_cnt_next;
    rsh_pkg::item_t                  item_reg;
    rsh_pkg::item_t                  item_next;
    rsh_pkg::item_t                  rd_item;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [rsh_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                            out_free;
    logic                            out_load;

    logic [rsh_pkg::ROW_W-1:0]       raddr [rsh_pkg::BANKS];
    logic [rsh_pkg::ROW_W-1:0]       waddr [rsh_pkg::BANKS];
    logic [rsh_pkg::BANKS-1:0]       we;
    logic [COUNT_WIDTH-1:0]          wdata [rsh_pkg::BANKS];
    logic [COUNT_WIDTH-1:0]          rdata [rsh_pkg::BANKS];
    logic [COUNT_WIDTH-1:0]          bumped [rsh_pkg::BANKS];
    logic [rsh_pkg::OUT_W-1:0]       reported [rsh_pkg::BANKS];
    logic [rsh_pkg::BANKS-1:0]       count_en;

    assign rd_item = (state_reg == ST_IDLE) ? pop_item : item_reg;
    assign count_en = {item_reg.sum_en, 3'b111};

    always_comb
    begin
        raddr[rsh_pkg::BANK_RED]   = rd_item.addr_red;
        raddr[rsh_pkg::BANK_GREEN] = rd_item.addr_green;
        raddr[rsh_pkg::BANK_BLUE]  = rd_item.addr_blue;
        for (int k = rsh_pkg::BANK_SUM0; k < rsh_pkg::BANKS; k++)
        begin
            raddr[k] = rd_item.addr_sum;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < rsh_pkg::BANKS; gi++)
        begin : g_bank
            logic [COUNT_WIDTH-1:0] mem [rsh_pkg::ROWS];

            always_ff @(posedge clk)
            begin
                if (we[gi])
                begin
                    mem[waddr[gi]] <= wdata[gi];
                end
                rdata[gi] <= mem[raddr[gi]];
            end

            assign bumped[gi] = (rdata[gi] == '1) ? rdata[gi] : rdata[gi] + 1'b1;

            if (COUNT_WIDTH > rsh_pkg::OUT_W)
            begin : g_sat
                assign reported[gi] = (|rdata[gi][COUNT_WIDTH-1:rsh_pkg::OUT_W]) ?
                                      '1 : rdata[gi][rsh_pkg::OUT_W-1:0];
            end
            else if (COUNT_WIDTH == rsh_pkg::OUT_W)
            begin : g_same
                assign reported[gi] = rdata[gi];
            end
            else
            begin : g_ext
                assign reported[gi] = {{(rsh_pkg::OUT_W-COUNT_WIDTH){1'b0}}, rdata[gi]};
            end
        end
    endgenerate

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        pop_ready    = 1'b0;
        out_load     = 1'b0;
        we           = '0;
        for (int k = 0; k < rsh_pkg::BANKS; k++)
        begin
            waddr[k] = raddr[k];
            wdata[k] = '0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                we           = '1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                for (int k = 0; k < rsh_pkg::BANKS; k++)
                begin
                    waddr[k] = clr_cnt_reg;
                end
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    item_next  = pop_item;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!item_reg.is_read)
                begin
                    we         = count_en;
                    state_next = ST_IDLE;
                    for (int k = 0; k < rsh_pkg::BANKS; k++)
                    begin
                        wdata[k] = bumped[k];
                    end
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    we         = {rsh_pkg::BANKS{item_reg.clear}};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (out_load)
        begin
            for (int k = 0; k < rsh_pkg::BANKS; k++)
            begin
                out_data_reg[k*rsh_pkg::OUT_W +: rsh_pkg::OUT_W] <= reported[k];
            end
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !(pop_valid && pop_ready))
        else $error("item taken during clearing pass");

    a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (we != '0) |-> (state_reg != ST_IDLE))
        else $error("bin write while idle");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_cnt_reg == '1) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not end");

endmodule
